>>> src/stw_pkg.sv
// Shared types, constants and the seven-segment encoder for the stopwatch.
// No dependencies.
package stw_pkg;

    localparam int DEBOUNCE_SAMPLES_DEF = 8;
    localparam int DISPLAY_DIGITS_DEF   = 6;
    localparam int KEY_COUNT_DEF        = 4;

    localparam int INPUT_KEYS     = 4;
    localparam int KEY_CLEAR      = 1;
    localparam int KEY_START_STOP = 2;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;
    localparam int DIGIT_W  = 3;
    localparam int HUND_W   = 7;
    localparam int SEC_W    = 14;

    localparam logic [7:0] TPH_RESET = 8'd5;
    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] DP_MASK   = 8'h7F;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        bcd_t [3:0] sec;
        bcd_t [1:0] hund;
    } counts_t;

    typedef struct packed {
        logic clear;
        logic start_stop;
    } key_events_t;

    function automatic logic [7:0] seg_encode(input bcd_t d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

>>> src/stw_debounce.sv
// Key debouncers: shift-history per key, stable level, falling-edge events.
// Depends on stw_pkg.
module stw_debounce #(
    parameter int DEBOUNCE_SAMPLES = stw_pkg::DEBOUNCE_SAMPLES_DEF,
    parameter int KEY_COUNT        = stw_pkg::KEY_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 tick,
    input  logic [stw_pkg::INPUT_KEYS-1:0]       key_level,
    output stw_pkg::key_events_t                 events
);
    import stw_pkg::*;

    logic [KEY_COUNT-1:0][DEBOUNCE_SAMPLES-1:0] hist_reg, hist_next;
    logic [KEY_COUNT-1:0]                       stable_reg, stable_next;
    logic [KEY_COUNT-1:0]                       fall;

    always_comb
    begin
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            logic lvl;
            lvl = (k < INPUT_KEYS) ? key_level[k % INPUT_KEYS] : 1'b1;
            hist_next[k]   = {hist_reg[k][DEBOUNCE_SAMPLES-2:0], lvl};
            stable_next[k] = stable_reg[k];
            if (hist_next[k] == '0)
                stable_next[k] = 1'b0;
            else if (hist_next[k] == '1)
                stable_next[k] = 1'b1;
            fall[k] = stable_reg[k] & ~stable_next[k];
        end
        events.clear      = tick & fall[KEY_CLEAR];
        events.start_stop = tick & fall[KEY_START_STOP];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg   <= '1;
            stable_reg <= '1;
        end
        else if (tick)
        begin
            hist_reg   <= hist_next;
            stable_reg <= stable_next;
        end
    end

endmodule

>>> src/stw_counter.sv
// Run flag, tick divider, divider register and decimal counts.
// Depends on stw_pkg.
module stw_counter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  stw_pkg::key_events_t events,
    output stw_pkg::counts_t     counts_next,
    output logic                 run_next
);
    import stw_pkg::*;

    logic [7:0] tph_reg;
    logic [7:0] div_reg, div_next;
    logic       run_reg;
    counts_t    counts_reg;
    logic       step;
    logic [5:0] carry;
    bcd_t [5:0] dig_cur, dig_inc;

    assign dig_cur = {counts_reg.sec, counts_reg.hund};

    always_comb
    begin
        div_next = div_reg + 8'd1;
        step     = 1'b0;
        if (div_next >= tph_reg)
        begin
            div_next = '0;
            step     = run_reg;
        end
        carry[0] = step;
        for (int i = 0; i < 6; i++)
        begin
            dig_inc[i] = dig_cur[i];
            if (carry[i])
                dig_inc[i] = (dig_cur[i] < 4'd9) ? dig_cur[i] + 4'd1 : 4'd0;
            if (i < 5)
                carry[(i + 1) % 6] = carry[i] & (dig_cur[i] >= 4'd9);
        end
        {counts_next.sec, counts_next.hund} = dig_inc;
        run_next = run_reg;
        if (events.clear)
        begin
            run_next    = 1'b0;
            counts_next = '0;
        end
        if (events.start_stop)
            run_next = ~run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tph_reg <= TPH_RESET;
        else if (cfg_wr_en)
            tph_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg    <= '0;
            run_reg    <= 1'b0;
            counts_reg <= '0;
        end
        else if (tick)
        begin
            div_reg    <= div_next;
            run_reg    <= run_next;
            counts_reg <= counts_next;
        end
    end

endmodule

>>> src/stw_display.sv
// Display store and scan position: drives one digit per tick; the store refreshes every tick.
// Depends on stw_pkg.
module stw_display #(
    parameter int DISPLAY_DIGITS = stw_pkg::DISPLAY_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  stw_pkg::counts_t              counts_next,
    output logic [stw_pkg::DIGIT_W-1:0]   digit_select,
    output logic [7:0]                    segment_byte
);
    import stw_pkg::*;

    localparam int POS_W = $clog2(DISPLAY_DIGITS);

    logic [POS_W-1:0]                  pos_reg, pos_next;
    logic [DISPLAY_DIGITS-1:0][7:0]    store_reg, store_next;

    assign digit_select = DIGIT_W'(pos_reg);
    assign segment_byte = store_reg[pos_reg];

    always_comb
    begin
        pos_next = (32'(pos_reg) + 32'd1 < DISPLAY_DIGITS) ? pos_reg + 1'b1 : '0;
        store_next    = '1;
        store_next[0] = seg_encode(counts_next.hund[0]);
        store_next[1] = seg_encode(counts_next.hund[1]);
        store_next[2] = seg_encode(counts_next.sec[0]) & DP_MASK;
        if (counts_next.sec[3] != '0 || counts_next.sec[2] != '0
            || counts_next.sec[1] != '0)
            store_next[3] = seg_encode(counts_next.sec[1]);
        if (counts_next.sec[3] != '0 || counts_next.sec[2] != '0)
            store_next[4] = seg_encode(counts_next.sec[2]);
        if (counts_next.sec[3] != '0)
            store_next[5] = seg_encode(counts_next.sec[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            store_reg <= '1;
        end
        else if (tick)
        begin
            pos_reg   <= pos_next;
            store_reg <= store_next;
        end
    end

endmodule

>>> src/stopwatch_with_key_debounce_display.sv
// Top level of the stopwatch: debounce, counter, display scan, output register.
// Depends on stw_pkg, stw_debounce, stw_counter, stw_display.
//
//  channel   dir  width  handshake             contents
//  s_axis    in   8      tvalid/tready         key levels, one word per tick
//  m_axis    out  40     tvalid/tready         digit, segments, run flag, counts
//  cfg       in   8      cfg_wr_en, no wait    ticks_per_hundredth
//
// One word in, one word out; a new word every cycle while the output is not stalled.
// The state updates at the accepting edge; the result lands in the output
// register that same edge. s_axis_tready drops only while that register is
// full and m_axis_tready is low. Reset clears all but the output data at once.
module stopwatch_with_key_debounce_display #(
    parameter int DEBOUNCE_SAMPLES = stw_pkg::DEBOUNCE_SAMPLES_DEF,
    parameter int DISPLAY_DIGITS   = stw_pkg::DISPLAY_DIGITS_DEF,
    parameter int KEY_COUNT        = stw_pkg::KEY_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // key0_level, key1_level, key2_level, key3_level, zero pad
    input  logic [stw_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // digit_select[2:0], segment_byte[10:3], is_running[11],
    // hundredths[18:12], whole_seconds[32:19], zero pad
    output logic [stw_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data
);
    import stw_pkg::*;

    logic                   tick;
    key_events_t            events;
    counts_t                counts_next;
    logic                   run_next;
    logic [DIGIT_W-1:0]     digit_select;
    logic [7:0]             segment_byte;
    logic [HUND_W-1:0]      hund_bin;
    logic [SEC_W-1:0]       sec_bin;
    logic                   out_valid_reg;
    logic [M_DATA_W-1:0]    out_data_reg, out_data_next;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign tick          = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    stw_debounce #(
        .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
        .KEY_COUNT        (KEY_COUNT)
    ) u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .key_level (s_axis_tdata[INPUT_KEYS-1:0]),
        .events    (events)
    );

    stw_counter u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .events      (events),
        .counts_next (counts_next),
        .run_next    (run_next)
    );

    stw_display #(
        .DISPLAY_DIGITS (DISPLAY_DIGITS)
    ) u_display (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .counts_next  (counts_next),
        .digit_select (digit_select),
        .segment_byte (segment_byte)
    );

    always_comb
    begin
        hund_bin = HUND_W'(counts_next.hund[0]) + HUND_W'(counts_next.hund[1]) * HUND_W'(10);
        sec_bin  = SEC_W'(counts_next.sec[0])
                 + SEC_W'(counts_next.sec[1]) * SEC_W'(10)
                 + SEC_W'(counts_next.sec[2]) * SEC_W'(100)
                 + SEC_W'(counts_next.sec[3]) * SEC_W'(1000);
        out_data_next = M_DATA_W'({sec_bin, hund_bin, run_next, segment_byte, digit_select});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (tick)
            out_data_reg <= out_data_next;
    end

endmodule

>>> src/stw_checker.sv
// Port-level checks for the stopwatch top level, attached by bind.
// Depends on stw_pkg.
module stw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [stw_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import stw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word gave no result");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:12] <= 7'd99 && m_axis_tdata[32:19] <= 14'd9999)
        else $error("count out of range");

endmodule

bind stopwatch_with_key_debounce_display stw_checker u_stw_checker (.*);
